/* rtl/fisr_pkg.sv */
package fisr_pkg;

   localparam int          PIPE_STAGES     = 10;

   localparam logic [31:0] MAGIC_GUESS     = 32'h5f3759df;
   localparam logic [31:0] F_HALF          = 32'h3F000000;
   localparam logic [31:0] F_THREE_HALVES  = 32'h3FC00000;
   localparam logic [31:0] F_SIGN          = 32'h80000000;
   localparam logic [31:0] F_INF           = 32'h7F800000;
   localparam logic [31:0] F_QUIET         = 32'h00400000;
   localparam logic [31:0] F_DEFAULT_NAN   = 32'h7FC00000;

   function automatic logic is_nan(input logic [31:0] a);
      return a[30:0] > F_INF[30:0];
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      return a[30:0] == F_INF[30:0];
   endfunction

   function automatic logic is_zero(input logic [31:0] a);
      return a[30:0] == 31'd0;
   endfunction

   function automatic logic [23:0] sig_of(input logic [31:0] a);
      return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
   endfunction

   function automatic logic [9:0] exp_of(input logic [31:0] a);
      return (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
   endfunction

   // round and pack m * 2^k; m is 64 bits, k signed
   function automatic logic [31:0] pack(input logic sign, input logic signed [11:0] k,
                                        input logic [63:0] m);
      logic [6:0]  p;
      logic signed [12:0] e;
      logic signed [12:0] sh;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [31:0] u;
      p = 7'd0;
      for (int i = 0; i < 64; i++) begin
         if (m[i]) p = 7'(i);
      end
      e  = 13'(signed'({6'd0, p})) + 13'(k) + 13'sd127;
      sh = 13'(signed'({6'd0, p})) - 13'sd23;
      if (e < 13'sd1) sh = -13'sd149 - 13'(k);
      if (m == 64'd0) return {sign, 31'd0};
      if (sh <= 13'sd0) begin
         q = m << 6'(-sh);
      end else if (sh >= 13'sd64) begin
         q = 64'd0;
      end else begin
         q    = m >> 6'(sh);
         rem  = m & ((64'd1 << 6'(sh)) - 64'd1);
         half = 64'd1 << 6'(sh - 13'sd1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
      if (e < 13'sd1) return {sign, q[30:0]};
      if (e >= 13'sd255) return {sign, F_INF[30:0]};
      u = {e[8:0] - 9'd1, 23'd0} + q[31:0];
      if (u >= F_INF) u = F_INF;
      return {sign, u[30:0]};
   endfunction

   // multiply stage 1: special cases and significand product
   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        sign;
      logic signed [11:0] k;
      logic [47:0] prod;
   } mul_mid_type;

endpackage

/* rtl/fisr_fmul.sv */
// two-stage float multiply: product register, then round and pack
module fisr_fmul (
   input  logic        clock,
   input  logic        adv_a,
   input  logic        adv_b,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y_ff
);
   import fisr_pkg::*;

   mul_mid_type mid_in, mid_ff;
   logic [31:0] y_in;

   always_comb begin
      mid_in.sign        = a[31] ^ b[31];
      mid_in.special     = 1'b1;
      mid_in.special_val = {mid_in.sign, 31'd0};
      mid_in.k           = 12'(signed'({2'b00, exp_of(a)}) + signed'({2'b00, exp_of(b)}))
                           - 12'sd300;
      mid_in.prod        = sig_of(a) * sig_of(b);
      if (is_nan(a)) mid_in.special_val = a | F_QUIET;
      else if (is_nan(b)) mid_in.special_val = b | F_QUIET;
      else if (is_inf(a) || is_inf(b)) begin
         if (is_zero(a) || is_zero(b)) mid_in.special_val = F_DEFAULT_NAN;
         else mid_in.special_val = {mid_in.sign, F_INF[30:0]};
      end else if (!(is_zero(a) || is_zero(b))) mid_in.special = 1'b0;
   end

   always_comb begin
      y_in = mid_ff.special ? mid_ff.special_val
           : pack(mid_ff.sign, mid_ff.k, {16'd0, mid_ff.prod});
   end

   always_ff @(posedge clock) begin
      if (adv_a) mid_ff <= mid_in;
      if (adv_b) y_ff <= y_in;
   end
endmodule

/* rtl/fisr_fsub.sv */
// two-stage 1.5 - t: align and add, then round and pack
module fisr_fsub (
   input  logic        clock,
   input  logic        adv_a,
   input  logic        adv_b,
   input  logic [31:0] t,
   output logic [31:0] y_ff
);
   import fisr_pkg::*;

   logic        spec_in, spec_ff, sgn_in, sgn_ff;
   logic [31:0] sval_in, sval_ff, y_in;
   logic signed [11:0] k_in, k_ff;
   logic [63:0] m_in, m_ff;

   always_comb begin
      logic [31:0] aa, bb, tmp;
      logic sa, sb, ts;
      logic [9:0] ea, eb, d;
      logic [63:0] ma, mb, full, lost;
      aa = F_THREE_HALVES;
      bb = t ^ F_SIGN;
      tmp  = 32'd0;
      ts   = 1'b0;
      ea   = 10'd0;
      eb   = 10'd0;
      d    = 10'd0;
      ma   = 64'd0;
      mb   = 64'd0;
      full = 64'd0;
      lost = 64'd0;
      spec_in = 1'b1;
      sval_in = 32'd0;
      sgn_in  = 1'b0;
      k_in    = 12'sd0;
      m_in    = 64'd0;
      sa = aa[31];
      sb = bb[31];
      if (is_nan(t)) sval_in = t | F_QUIET;
      else if (is_inf(bb)) sval_in = bb;
      else if (is_zero(bb)) sval_in = aa;
      else begin
         if (exp_of(aa) < exp_of(bb)) begin
            tmp = aa; aa = bb; bb = tmp; ts = sa; sa = sb; sb = ts;
         end
         ea = exp_of(aa);
         eb = exp_of(bb);
         d  = ea - eb;
         ma = {40'd0, sig_of(aa)} << 39;
         full = {40'd0, sig_of(bb)} << 39;
         if (d >= 10'd63) mb = 64'd1;
         else begin
            lost = full & ((64'd1 << d[5:0]) - 64'd1);
            mb = (full >> d[5:0]) | {63'd0, lost != 64'd0};
         end
         k_in = 12'(signed'({2'b00, ea})) - 12'sd189;
         spec_in = 1'b0;
         if (sa == sb) begin
            sgn_in = sa; m_in = ma + mb;
         end else if (ma == mb) begin
            spec_in = 1'b1; sval_in = 32'd0;
         end else if (ma > mb) begin
            sgn_in = sa; m_in = ma - mb;
         end else begin
            sgn_in = sb; m_in = mb - ma;
         end
      end
   end

   assign y_in = spec_ff ? sval_ff : pack(sgn_ff, k_ff, m_ff);

   always_ff @(posedge clock) begin
      if (adv_a) begin
         spec_ff <= spec_in;
         sval_ff <= sval_in;
         sgn_ff  <= sgn_in;
         k_ff    <= k_in;
         m_ff    <= m_in;
      end
      if (adv_b) y_ff <= y_in;
   end
endmodule

/* rtl/fast_inverse_square_root_core.sv */
// Throughput: one beat per cycle while the pipe is not stalled; ten stages, each a multiply, an add or a round/pack.
// Stalls freeze the whole pipe when the rsp side holds off and the output stage is full.
// Reset (synchronous, active high) clears the stage valid bits; data is not reset.
module fast_inverse_square_root_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] result_bits
);
   import fisr_pkg::*;

   logic [PIPE_STAGES-1:0] vld_ff, vld_in;
   logic              adv;
   logic [31:0]       half_w, t1_w, t2_w, t3_w, y_w;
   logic [31:0]       g_ff [PIPE_STAGES-3:0];
   logic [31:0]       g_in;

   // advance the whole pipe unless the output beat is held
   assign adv        = ~vld_ff[PIPE_STAGES-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PIPE_STAGES-1];
   assign rsp_tdata  = y_w;

   // integer first guess from the raw bits, arithmetic shift
   assign g_in = MAGIC_GUESS - {req_tdata[31], req_tdata[31:1]};

   always_comb begin
      vld_in = {vld_ff[PIPE_STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // carry the guess along beside the arithmetic
   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff[0] <= g_in;
         for (int i = 1; i < PIPE_STAGES - 2; i++) g_ff[i] <= g_ff[i-1];
      end
   end

   // stages 1-2: half = x * 0.5
   fisr_fmul u_half (.clock, .adv_a(adv), .adv_b(adv),
                     .a(req_tdata), .b(F_HALF), .y_ff(half_w));
   // stages 3-4: half * guess
   fisr_fmul u_m1 (.clock, .adv_a(adv), .adv_b(adv),
                   .a(half_w), .b(g_ff[1]), .y_ff(t1_w));
   // stages 5-6: times guess
   fisr_fmul u_m2 (.clock, .adv_a(adv), .adv_b(adv),
                   .a(t1_w), .b(g_ff[3]), .y_ff(t2_w));
   // stages 7-8: 1.5 - t
   fisr_fsub u_sub (.clock, .adv_a(adv), .adv_b(adv),
                    .t(t2_w), .y_ff(t3_w));
   // stages 9-10: guess * t
   fisr_fmul u_m3 (.clock, .adv_a(adv), .adv_b(adv),
                   .a(g_ff[7]), .b(t3_w), .y_ff(y_w));

endmodule
